FILE: hdl/sha1_pkg.sv
package sha1_pkg;

  // Initial chaining words.
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [2:0] LastDigest = 3'd4;
  localparam logic [31:0] PadFirstWord = 32'h80000000;

  // Five 32-bit words, index 0 is the most significant digest word.
  typedef logic [4:0][31:0] words5_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_ADD   = 5'b00100,
    S_FILL2 = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // Control of the block buffer and message schedule.
  typedef struct packed {
    logic        wr_en;      // store one full message word
    logic        last_en;    // store the final word with padding
    logic        fill2_en;   // build the extra block that carries the length
    logic        shift_en;   // advance the schedule by one round
    logic [3:0]  idx;        // word slot being written
    logic [31:0] word;
    logic [2:0]  cnt;        // valid bytes, already saturated to four
    logic        two_blk;    // padding spills into a second block
    logic        pad_first;  // pad byte opens the second block
    logic [63:0] len;        // message length in bits
  } buf_ctl_t;

  // Control of the round unit and chaining words.
  typedef struct packed {
    logic       start;
    logic       round_en;
    logic       add_en;
    logic       init_en;
    logic [6:0] round;
  } core_ctl_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

  // Keeps the valid top bytes of the final word and appends the pad byte.
  // With four valid bytes the pad byte belongs to the following word.
  function automatic logic [31:0] last_word_pad(input logic [31:0] w, input logic [2:0] cnt);
    logic [31:0] r;
    unique case (cnt)
      3'd0: r = 32'h80000000;
      3'd1: r = {w[31:24], 24'h800000};
      3'd2: r = {w[31:16], 16'h8000};
      3'd3: r = {w[31:8], 8'h80};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/sha1_msg_buf.sv
module sha1_msg_buf (
  input  logic              clk,
  input  sha1_pkg::buf_ctl_t ctl,
  output logic [31:0]       w0
);
  import sha1_pkg::*;

  logic [31:0] buffer [16];
  logic [31:0] buffer_next [16];
  logic [31:0] sched_word;

  // New schedule word from the taps of the sixteen-word window.
  assign sched_word = rotl1(buffer[13] ^ buffer[8] ^ buffer[2] ^ buffer[0]);
  assign w0 = buffer[0];

  // Per-entry next value, chosen for each slot by its own position.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      buffer_next[i] = buffer[i];
      if (ctl.shift_en) begin
        buffer_next[i] = (i == 15) ? sched_word : buffer[4'(i + 1)];
      end else if (ctl.wr_en) begin
        if (4'(i) == ctl.idx) buffer_next[i] = ctl.word;
      end else if (ctl.last_en) begin
        if (4'(i) == ctl.idx) begin
          buffer_next[i] = last_word_pad(ctl.word, ctl.cnt);
        end else if ((5'(i) == {1'b0, ctl.idx} + 5'd1) && (ctl.cnt == 3'd4)) begin
          buffer_next[i] = PadFirstWord;
        end else if (4'(i) > ctl.idx) begin
          buffer_next[i] = '0;
        end
        // Length goes straight in when the padding fits in this block.
        if (!ctl.two_blk && i == 14) buffer_next[i] = ctl.len[63:32];
        if (!ctl.two_blk && i == 15) buffer_next[i] = ctl.len[31:0];
      end else if (ctl.fill2_en) begin
        if (i == 0) buffer_next[i] = ctl.pad_first ? PadFirstWord : '0;
        else if (i == 14) buffer_next[i] = ctl.len[63:32];
        else if (i == 15) buffer_next[i] = ctl.len[31:0];
        else buffer_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    buffer <= buffer_next;
  end

endmodule

FILE: hdl/sha1_core.sv
module sha1_core (
  input  logic                clk,
  input  logic                rst,
  input  sha1_pkg::core_ctl_t ctl,
  input  logic [31:0]         w,
  output sha1_pkg::words5_t   chain
);
  import sha1_pkg::*;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, t;

  // Round function and constant chosen by the round group.
  always_comb begin
    priority if (ctl.round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctl.round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctl.round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t = rotl5(a) + f + e + w + k;

  // Working variables: loaded from the chain, then one round a cycle.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctl.round_en) begin
      a <= t;
      b <= a;
      c <= rotl30(b);
      d <= c;
      e <= d;
    end
  end

  // Chaining words: initial values at reset and after the last digest, updated after each block.
  always_ff @(posedge clk) begin
    if (rst || ctl.init_en) begin
      chain <= {H4, H3, H2, H1, H0};
    end else if (ctl.add_en) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

endmodule

FILE: hdl/sha1_stream_hasher_top.sv
// SHA-1 hasher for one message at a time. Message words arrive big-endian
// on the input channel; the item flagged last_item may carry 0 to 4 bytes
// (counts above four are taken as four) and ends the message, after which
// the five digest words leave on the output channel, word_index 0 first,
// and the block starts afresh for the next message. A word that does not
// complete a 64-byte block is taken without leaving the idle state. The
// word that completes a block, and the last word, hold the input through
// each compressed block (a load of the working words, 80 rounds, one
// chaining add): the single round unit does one of the 80 rounds each
// cycle. The last word causes one compression, or two when the padding
// does not fit in the current block, followed by the five digest
// transactions. The input is not ready while the digest is shown.
module sha1_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] message_word,
  input  logic [2:0]  byte_count,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  state_t      state, state_next;
  logic [6:0]  round;
  logic [3:0]  wr_idx;
  logic [63:0] bit_length, bit_length_next;
  logic [2:0]  out_idx;
  logic        pend2, pad_first, fin;

  logic        in_acc, out_acc;
  logic [2:0]  cnt_sat;
  logic [6:0]  pos;
  logic        two_blk, pos64;
  buf_ctl_t    bctl;
  core_ctl_t   cctl;
  logic [31:0] w0;
  words5_t     chain;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Final-word byte count and where the pad byte lands.
  assign cnt_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;
  assign pos     = {1'b0, wr_idx, 2'b00} + {4'd0, cnt_sat};
  assign two_blk = (pos >= 7'd56);
  assign pos64   = pos[6];

  // Running bit count.
  always_comb begin
    bit_length_next = bit_length;
    if (in_acc) begin
      if (last_item) bit_length_next = bit_length + {58'd0, cnt_sat, 3'd0};
      else bit_length_next = bit_length + 64'd32;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && (last_item || wr_idx == 4'd15)) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (round == LastRound) state_next = S_ADD;
      end
      S_ADD: begin
        if (pend2) state_next = S_FILL2;
        else if (fin) state_next = S_OUT;
        else state_next = S_IDLE;
      end
      S_FILL2: state_next = S_ROUND;
      S_OUT: begin
        if (out_acc && out_idx == LastDigest) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      round      <= '0;
      wr_idx     <= '0;
      bit_length <= '0;
      out_idx    <= '0;
      pend2      <= 1'b0;
      pad_first  <= 1'b0;
      fin        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROUND) begin
        round <= (round == LastRound) ? 7'd0 : round + 7'd1;
      end
      if (in_acc) begin
        bit_length <= bit_length_next;
        if (last_item) begin
          fin       <= 1'b1;
          pend2     <= two_blk;
          pad_first <= pos64;
        end else begin
          wr_idx <= wr_idx + 4'd1;
        end
      end
      if (state == S_ADD) begin
        pend2   <= 1'b0;
        out_idx <= '0;
      end
      if (out_acc) begin
        if (out_idx == LastDigest) begin
          out_idx    <= '0;
          wr_idx     <= '0;
          bit_length <= '0;
          fin        <= 1'b0;
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  // Buffer control.
  always_comb begin
    bctl.wr_en     = in_acc && !last_item;
    bctl.last_en   = in_acc && last_item;
    bctl.fill2_en  = (state == S_FILL2);
    bctl.shift_en  = (state == S_ROUND);
    bctl.idx       = wr_idx;
    bctl.word      = message_word;
    bctl.cnt       = cnt_sat;
    bctl.two_blk   = two_blk;
    bctl.pad_first = pad_first;
    bctl.len       = bit_length_next;
  end

  // Round unit control.
  always_comb begin
    cctl.start    = (state_next == S_ROUND) && (state != S_ROUND);
    cctl.round_en = (state == S_ROUND);
    cctl.add_en   = (state == S_ADD);
    cctl.init_en  = out_acc && (out_idx == LastDigest);
    cctl.round    = round;
  end

  sha1_msg_buf u_buf (
    .clk (clk),
    .ctl (bctl),
    .w0  (w0)
  );

  sha1_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cctl),
    .w     (w0),
    .chain (chain)
  );

  // Digest words are read straight from the chaining registers.
  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == LastDigest);

  // The input and the digest are never offered together.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while digest is offered");

  // Rounds end after the eightieth and hand over to the chaining add.
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == LastRound) |=> (state == S_ADD && round == 7'd0))
    else $error("round sequence did not end at round 79");

  // Round counter stays at zero outside a compression.
  a_round_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND) |-> (round == 7'd0))
    else $error("round counter running outside compression");

  // After the final digest word the message state is back at its start.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_idx == LastDigest) |=>
      (chain[0] == H0 && chain[4] == H4 && bit_length == 64'd0 && wr_idx == 4'd0))
    else $error("state not restored after digest");

  // A digest is only shown after a last item has been taken.
  a_digest_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fin)
    else $error("digest offered without a finished message");

endmodule

FILE: verif/sha1_stream_hasher_top_tb.sv
module sha1_stream_hasher_top_tb;
  import sha1_pkg::*;

  // Idling behaviour of the two channels, chosen per queued input word.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One input transaction waiting to be offered to the hasher.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        fin;
    idle_mode_t  mode;
    bit          drain;    // hold this word back until every digest word is out
    bit          hold_rx;  // ask the receiver for a long hold-off when offered
  } msg_word_t;

  // One digest word that the hasher owes us.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        fin;
  } digest_word_t;

  localparam int RandomWords    = 180;
  localparam int RxHoldCycles   = 400;
  localparam int WatchdogLimit  = 4000;
  localparam int DrainCycles    = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] message_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha1_stream_hasher_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .message_word (message_word),
    .byte_count   (byte_count),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  msg_word_t    pending_words[$];
  digest_word_t expected_digest[$];
  int           total_words;
  int           words_accepted;
  int           mismatches;
  int           hold_requests;
  int           hold_served;
  idle_mode_t   cur_mode = IDLE_NONE;

  // Our own copy of the hashing state.
  logic [31:0] chain [5];
  logic [31:0] blk [16];
  logic [63:0] msg_bits;
  int unsigned fill;

  // Returns the hashing state to the start of a fresh message.
  function automatic void restart_hash();
    chain[0] = H0;
    chain[1] = H1;
    chain[2] = H2;
    chain[3] = H3;
    chain[4] = H4;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    msg_bits = '0;
    fill = 0;
  endfunction

  // Runs the 80 rounds over the block buffer and folds the result into the chain.
  function automatic void compress_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int i;
    for (i = 0; i < 16; i++) sched[i] = blk[i];
    for (i = 16; i < 80; i++) begin
      t = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
      sched[i] = {t[30:0], t[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + sched[i] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // Takes one accepted input word into the hash and, on the final word,
  // queues the five digest words that must follow.
  function automatic void absorb_word(input logic [31:0] w, input logic [2:0] cnt,
                                      input logic fin);
    int unsigned idx;
    int unsigned n;
    int unsigned pos;
    digest_word_t dw;
    idx = (fill >> 2) & 15;
    if (!fin) begin
      blk[idx] = w;
      msg_bits += 64'd32;
      fill = (fill + 4) & 63;
      if (idx == 15) compress_block();
      return;
    end
    // Counts above four saturate; bits below the valid bytes are dropped.
    n = (cnt > 4) ? 4 : cnt;
    if (n == 0) w = '0;
    else w &= 32'hffffffff << (32 - 8 * n);
    msg_bits += 64'(8 * n);
    blk[idx] = w;
    for (int i = idx + 1; i < 16; i++) blk[i] = '0;
    pos = idx * 4 + n;
    if (pos >= 64) begin
      compress_block();
      for (int i = 0; i < 16; i++) blk[i] = '0;
      blk[0] = PadFirstWord;
    end else begin
      blk[pos >> 2] |= 32'h80 << (24 - 8 * (pos % 4));
      // No room left for the length: it goes in a block of its own.
      if (pos >= 56) begin
        compress_block();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
    end
    blk[14] = msg_bits[63:32];
    blk[15] = msg_bits[31:0];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      dw.word = chain[i];
      dw.index = 3'(i);
      dw.fin = (3'(i) == LastDigest);
      expected_digest.push_back(dw);
    end
    restart_hash();
  endfunction

  function automatic void queue_word(input logic [31:0] w, input logic [2:0] cnt,
                                     input logic fin, input idle_mode_t mode,
                                     input bit drain = 1'b0, input bit hold_rx = 1'b0);
    msg_word_t m;
    m.word = w;
    m.nbytes = cnt;
    m.fin = fin;
    m.mode = mode;
    m.drain = drain;
    m.hold_rx = hold_rx;
    pending_words.push_back(m);
  endfunction

  // Stimulus: a directed opening, then random messages over four idling phases.
  initial begin
    int random_count;
    int msg_count;
    int nwords;
    idle_mode_t mode;
    idle_mode_t prev_mode;
    bit first;
    restart_hash();

    // Empty message, with stray bits that must be masked away.
    queue_word(32'hffffffff, 3'd0, 1'b1, IDLE_NONE);
    // One byte with stray bits below it.
    queue_word(32'h61ffffff, 3'd1, 1'b1, IDLE_NONE);
    // Short word that is not last counts as four bytes; count seven saturates.
    queue_word(32'h00000000, 3'd0, 1'b0, IDLE_NONE);
    queue_word(32'hffffffff, 3'd7, 1'b1, IDLE_NONE);
    queue_word(32'h12345678, 3'd5, 1'b1, IDLE_NONE);
    queue_word(32'h00000000, 3'd6, 1'b1, IDLE_NONE);
    // Fourteen full words then four bytes: the pad byte falls past byte 55.
    queue_word(32'hffffffff, 3'd4, 1'b0, IDLE_NONE);
    queue_word(32'h00000000, 3'd4, 1'b0, IDLE_NONE);
    queue_word(32'h5a5a5a5a, 3'd2, 1'b0, IDLE_NONE);
    for (int i = 3; i < 14; i++) queue_word($urandom, 3'd4, 1'b0, IDLE_NONE);
    queue_word(32'ha5a5a5a5, 3'd4, 1'b1, IDLE_NONE);

    random_count = 0;
    msg_count = 0;
    prev_mode = IDLE_NONE;
    while (random_count < RandomWords) begin
      mode = idle_mode_t'((random_count * 4) / RandomWords);
      case ($urandom_range(0, 9))
        0, 1, 2: nwords = 16 * $urandom_range(0, 1) + $urandom_range(13, 15);
        3:       nwords = $urandom_range(16, 48);
        default: nwords = $urandom_range(0, 12);
      endcase
      first = 1'b1;
      for (int j = 0; j <= nwords; j++) begin
        // Drain at each change of phase and at random; one early message asks for a long
        // receiver hold-off so that the input backs up behind the digest.
        queue_word($urandom,
                   (j == nwords) ? (($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                                                 : 3'($urandom_range(0, 4)))
                                 : (($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                                 : 3'd4),
                   (j == nwords), mode,
                   first && (mode != prev_mode || $urandom_range(0, 7) == 0),
                   first && (msg_count == 2));
        first = 1'b0;
      end
      prev_mode = mode;
      msg_count++;
      random_count += nwords + 1;
    end
    total_words = pending_words.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (words_accepted == total_words);
    while (expected_digest.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS sha1_stream_hasher_top");
    end else begin
      $display("FAIL sha1_stream_hasher_top");
    end
    $finish;
  end

  // Input driver: predicts each accepted transaction and offers the next word.
  logic      offer_busy;
  bit        can_offer;
  msg_word_t head;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer_busy = in_valid;
      if (in_valid && in_ready) begin
        absorb_word(message_word, byte_count, last_item);
        words_accepted++;
        offer_busy = 1'b0;
      end
      if (!offer_busy) begin
        can_offer = (pending_words.size() != 0);
        if (can_offer) begin
          head = pending_words[0];
          if (head.drain && expected_digest.size() != 0) can_offer = 1'b0;
          else if (head.mode == IDLE_SENDER && $urandom_range(0, 99) < 65) can_offer = 1'b0;
          else if (head.mode == IDLE_BOTH && $urandom_range(0, 99) < 7) can_offer = 1'b0;
        end
        if (can_offer) begin
          void'(pending_words.pop_front());
          cur_mode = head.mode;
          if (head.hold_rx) hold_requests++;
          in_valid <= 1'b1;
          message_word <= head.word;
          byte_count <= head.nbytes;
          last_item <= head.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each digest transaction and drives the stall pattern.
  int unsigned  hold_left;
  digest_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest word: expected none, actual %h index %0d last %b",
                   $time, digest_word, word_index, last_word);
          mismatches++;
        end else begin
          want = expected_digest.pop_front();
          if (digest_word !== want.word) begin
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, want.word, digest_word);
            mismatches++;
          end
          if (word_index !== want.index) begin
            $display("%0t: word_index mismatch: expected %0d, actual %0d",
                     $time, want.index, word_index);
            mismatches++;
          end
          if (last_word !== want.fin) begin
            $display("%0t: last_word mismatch: expected %b, actual %b",
                     $time, want.fin, last_word);
            mismatches++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = RxHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (cur_mode == IDLE_RECEIVER) begin
        out_ready <= ($urandom_range(0, 99) >= 65);
      end else if (cur_mode == IDLE_BOTH) begin
        out_ready <= ($urandom_range(0, 99) >= 7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction on either channel ends the run.
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("FAIL sha1_stream_hasher_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
hdl/sha1_pkg.sv
hdl/sha1_msg_buf.sv
hdl/sha1_core.sv
hdl/sha1_stream_hasher_top.sv
verif/sha1_stream_hasher_top_tb.sv
